/* src/drm_pkg.sv */
`default_nettype none
package drm_pkg;

	localparam int DEPTH = 16;
	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = 18;   // unsaturated cover size
	localparam int AW    = 2 * DW;
	localparam int SW    = AW + 4; // running area sum

	localparam logic [1:0] KIND_RECT   = 2'd0;
	localparam logic [1:0] KIND_CANVAS = 2'd1;
	localparam logic [1:0] KIND_DRAIN  = 2'd2;

	typedef enum logic [2:0] {
		ST_IGNORED  = 3'd0,
		ST_SUPER    = 3'd1,
		ST_MERGED   = 3'd2,
		ST_CONGLOM  = 3'd3,
		ST_APPENDED = 3'd4,
		ST_OVERFLOW = 3'd5,
		ST_EMIT     = 3'd6,
		ST_EMPTY    = 3'd7
	} st_t;

	typedef enum logic [1:0] { W_B, W_M, W_P } wsrc_t;
	typedef enum logic [1:0] { A_IDX, A_ZERO, A_CNT } wadr_t;

	// stored entry
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
	} ent_t;

	// working rectangle, size not yet saturated
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [DW-1:0]      w;
		logic [DW-1:0]      h;
	} bx_t;

	typedef struct packed {
		logic  ld_ins;
		logic  prep;
		logic  cmp;
		logic  mul;
		logic  step;
		logic  idx_clr;
		logic  pop;
		logic  inc_cnt;
		logic  wr;
		wsrc_t wsrc;
		wadr_t wadr;
		logic  pend_clr;
		logic  pend_ld;
		logic  res_v;
		st_t   res_st;
		logic  res_last;
	} cmd_t;

	typedef struct packed {
		logic hab;
		logic hba;
		logic mok;
		logic cok;
		logic at_end;
		logic full;
		logic empty;
		logic pend_v;
	} flg_t;

	function automatic bx_t widen(ent_t e);
		bx_t b;
		b.x = e.x;
		b.y = e.y;
		b.w = {{(DW-15){1'b0}}, e.w};
		b.h = {{(DW-15){1'b0}}, e.h};
		return b;
	endfunction

	function automatic ent_t sat(bx_t b);
		ent_t e;
		e.x = b.x;
		e.y = b.y;
		e.w = (b.w > DW'(32767)) ? 15'h7fff : b.w[14:0];
		e.h = (b.h > DW'(32767)) ? 15'h7fff : b.h[14:0];
		return e;
	endfunction

	function automatic logic signed [19:0] far(logic signed [15:0] p, logic [DW-1:0] d);
		return $signed({{4{p[15]}}, p}) + $signed({{(20-DW){1'b0}}, d});
	endfunction

	function automatic logic signed [19:0] sx(logic signed [15:0] p);
		return $signed({{4{p[15]}}, p});
	endfunction

	// a holds b
	function automatic logic holds(bx_t a, bx_t b);
		return (a.x <= b.x) && (a.y <= b.y) &&
			(far(a.x, a.w) >= far(b.x, b.w)) && (far(a.y, a.h) >= far(b.y, b.h));
	endfunction

	function automatic bx_t bbox(bx_t a, bx_t b);
		bx_t c;
		logic signed [19:0] r2;
		logic signed [19:0] b2;
		logic signed [19:0] dw;
		logic signed [19:0] dh;
		c.x = (a.x < b.x) ? a.x : b.x;
		c.y = (a.y < b.y) ? a.y : b.y;
		r2 = (far(a.x, a.w) > far(b.x, b.w)) ? far(a.x, a.w) : far(b.x, b.w);
		b2 = (far(a.y, a.h) > far(b.y, b.h)) ? far(a.y, a.h) : far(b.y, b.h);
		dw = r2 - sx(c.x);
		dh = b2 - sx(c.y);
		c.w = dw[DW-1:0];
		c.h = dh[DW-1:0];
		if (a.w == '0 || a.h == '0) c = b;
		else if (b.w == '0 || b.h == '0) c = a;
		return c;
	endfunction

endpackage
`default_nettype wire

/* src/drm_ctrl.sv */
`default_nettype none
module drm_ctrl
	import drm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] kind,
	input  wire flg_t       flg,
	output cmd_t            cmd,
	output logic            busy
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_PREP = 9'b000000010,
		S_CHK  = 9'b000000100,
		S_CMP  = 9'b000001000,
		S_MUL  = 9'b000010000,
		S_DEC  = 9'b000100000,
		S_OCMP = 9'b001000000,
		S_OWR  = 9'b010000000,
		S_DCHK = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   drn_q, drn_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			drn_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			drn_q   <= drn_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.wsrc     = W_B;
		cmd.wadr     = A_IDX;
		cmd.res_st   = ST_IGNORED;
		cmd.res_last = 1'b1;
		state_d      = state_q;
		drn_d        = drn_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					drn_d = (kind == KIND_DRAIN);
					if (kind == KIND_DRAIN) begin
						cmd.pend_clr = 1'b1;
						state_d      = S_DCHK;
					end else begin
						cmd.ld_ins = 1'b1;
						state_d    = S_PREP;
					end
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_CHK;
			end
			S_CHK: begin
				if (!flg.at_end) begin
					state_d = S_CMP;
				end else if (drn_q) begin
					// survivor: flush the held one, hold this one
					cmd.res_v    = flg.pend_v;
					cmd.res_st   = ST_EMIT;
					cmd.res_last = 1'b0;
					cmd.pend_ld  = 1'b1;
					state_d      = S_DCHK;
				end else if (!flg.full) begin
					cmd.wr      = 1'b1;
					cmd.wsrc    = W_B;
					cmd.wadr    = A_CNT;
					cmd.inc_cnt = 1'b1;
					cmd.res_v   = 1'b1;
					cmd.res_st  = ST_APPENDED;
					state_d     = S_IDLE;
				end else begin
					cmd.idx_clr = 1'b1;
					state_d     = S_OCMP;
				end
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				if (drn_q) begin
					if (flg.hab) begin
						state_d = S_DCHK;
					end else if (flg.mok) begin
						cmd.wr   = 1'b1;
						cmd.wsrc = W_M;
						state_d  = S_DCHK;
					end else begin
						cmd.step = 1'b1;
						state_d  = S_CHK;
					end
				end else begin
					priority if (flg.hab) begin
						cmd.res_v  = 1'b1;
						cmd.res_st = ST_IGNORED;
						state_d    = S_IDLE;
					end else if (flg.hba) begin
						cmd.wr     = 1'b1;
						cmd.wsrc   = W_B;
						cmd.res_v  = 1'b1;
						cmd.res_st = ST_SUPER;
						state_d    = S_IDLE;
					end else if (flg.mok) begin
						cmd.wr     = 1'b1;
						cmd.wsrc   = W_M;
						cmd.res_v  = 1'b1;
						cmd.res_st = ST_MERGED;
						state_d    = S_IDLE;
					end else if (flg.cok) begin
						cmd.wr     = 1'b1;
						cmd.wsrc   = W_P;
						cmd.wadr   = A_ZERO;
						cmd.res_v  = 1'b1;
						cmd.res_st = ST_CONGLOM;
						state_d    = S_IDLE;
					end else begin
						cmd.step = 1'b1;
						state_d  = S_CHK;
					end
				end
			end
			S_OCMP: begin
				cmd.cmp = 1'b1;
				state_d = S_OWR;
			end
			S_OWR: begin
				cmd.wr     = 1'b1;
				cmd.wsrc   = W_M;
				cmd.res_v  = 1'b1;
				cmd.res_st = ST_OVERFLOW;
				state_d    = S_IDLE;
			end
			S_DCHK: begin
				if (flg.empty) begin
					cmd.res_v  = 1'b1;
					cmd.res_st = flg.pend_v ? ST_EMIT : ST_EMPTY;
					state_d    = S_IDLE;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_PREP;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* src/drm_dp.sv */
`default_nettype none
module drm_dp
	import drm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	input  wire logic [1:0]         kind,
	input  wire logic signed [15:0] rect_x,
	input  wire logic signed [15:0] rect_y,
	input  wire logic [14:0]        rect_w,
	input  wire logic [14:0]        rect_h,
	input  wire logic [14:0]        cw,
	input  wire logic [14:0]        ch,
	output flg_t                    flg,
	output logic                    done,
	output logic [2:0]              status,
	output logic signed [15:0]      out_x,
	output logic signed [15:0]      out_y,
	output logic [14:0]             out_w,
	output logic [14:0]             out_h,
	output logic                    last
);

	ent_t            tbl [DEPTH];
	logic [CW-1:0]   cnt_q, idx_q;
	bx_t             b_q, prog_q, m_q, pn_q, a_q;
	logic            hab_q, hba_q;
	logic [AW-1:0]   ab_q, am_q, aa_q, ap_q;
	logic [SW-1:0]   cum_q;
	logic            pend_v_q;
	ent_t            pend_q;
	logic            done_q, last_q;
	st_t             st_q;
	ent_t            res_q;

	logic [CW-1:0]   cnt_m1;
	logic [IW-1:0]   raddr, waddr;
	bx_t             rd, wsel;
	bx_t             ins;

	assign cnt_m1 = cnt_q - CW'(1);
	assign raddr  = cmd.pop ? cnt_m1[IW-1:0] : idx_q[IW-1:0];
	assign rd     = widen(tbl[raddr]);

	always_comb begin
		ins.x = rect_x;
		ins.y = rect_y;
		ins.w = {{(DW-15){1'b0}}, rect_w};
		ins.h = {{(DW-15){1'b0}}, rect_h};
		if (kind == KIND_CANVAS) begin
			ins.x = '0;
			ins.y = '0;
			ins.w = {{(DW-15){1'b0}}, cw};
			ins.h = {{(DW-15){1'b0}}, ch};
		end
	end

	always_comb begin
		unique case (cmd.wsrc)
			W_M:     wsel = m_q;
			W_P:     wsel = pn_q;
			default: wsel = b_q;
		endcase
		unique case (cmd.wadr)
			A_ZERO:  waddr = '0;
			A_CNT:   waddr = cnt_q[IW-1:0];
			default: waddr = idx_q[IW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) tbl[waddr] <= sat(wsel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			idx_q    <= '0;
			pend_v_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.res_v;
			if (cmd.inc_cnt) cnt_q <= cnt_q + CW'(1);
			if (cmd.pop) cnt_q <= cnt_m1;
			if (cmd.ld_ins || cmd.pop || cmd.idx_clr) idx_q <= '0;
			else if (cmd.step) idx_q <= idx_q + CW'(1);
			if (cmd.pend_clr) pend_v_q <= 1'b0;
			else if (cmd.pend_ld) pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_ins) begin
			b_q    <= ins;
			prog_q <= ins;
			cum_q  <= '0;
		end
		if (cmd.pop) b_q <= rd;
		if (cmd.prep) ab_q <= b_q.w * b_q.h;
		if (cmd.cmp) begin
			a_q   <= rd;
			hab_q <= holds(rd, b_q);
			hba_q <= holds(b_q, rd);
			m_q   <= bbox(rd, b_q);
			pn_q  <= bbox(prog_q, rd);
		end
		if (cmd.mul) begin
			am_q <= m_q.w * m_q.h;
			aa_q <= a_q.w * a_q.h;
			ap_q <= pn_q.w * pn_q.h;
		end
		if (cmd.step) begin
			prog_q <= pn_q;
			cum_q  <= cum_q + SW'(aa_q);
		end
		if (cmd.pend_ld) pend_q <= sat(b_q);
		if (cmd.res_v) begin
			st_q   <= cmd.res_st;
			last_q <= cmd.res_last;
			res_q  <= (cmd.res_st == ST_EMIT) ? pend_q : '0;
		end
	end

	assign flg.hab    = hab_q;
	assign flg.hba    = hba_q;
	assign flg.mok    = ({1'b0, am_q} <= ({1'b0, aa_q} + {1'b0, ab_q}));
	assign flg.cok    = (SW'(ap_q) <= (cum_q + SW'(aa_q)));
	assign flg.at_end = (idx_q == cnt_q);
	assign flg.full   = (cnt_q == CW'(DEPTH));
	assign flg.empty  = (cnt_q == '0);
	assign flg.pend_v = pend_v_q;

	assign done   = done_q;
	assign status = st_q;
	assign last   = last_q;
	assign out_x  = res_q.x;
	assign out_y  = res_q.y;
	assign out_w  = res_q.w;
	assign out_h  = res_q.h;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("entry count past depth");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= cnt_q) else $error("walk index past entry count");
	a_zero_rect: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && st_q != ST_EMIT |-> res_q == '0) else $error("rectangle on non-emit result");
	a_ins_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && st_q != ST_EMIT |-> last_q) else $error("non-emit result without last");
`endif

endmodule
`default_nettype wire

/* src/dirty_rectangle_merge_table.sv */
// Dirty rectangle table, 16 entries. Pulse start with kind while busy is low:
// kind 0 (or 3) invalidates rect_x/y/w/h, kind 1 the whole canvas, kind 2
// drains the table. Results come on status/out_*/last with done high for one
// cycle only; the receiver cannot stall, so capture on every done. Inserts give
// one result; a drain gives one result per surviving rectangle (last on the
// final one) or a single drain-empty result. An insert runs prep and check,
// then compare, multiply and decide per entry walked, stopping at a match,
// plus an overflow compare and write when full; done rises in the same cycle
// that busy drops. A drain pops each entry, compares it with earlier entries
// until one absorbs it, checks a survivor once more and ends on a closing
// check. The walk runs through one shared compare/cover stage and one area
// multiply stage per entry. Canvas size registers (index 0 width, 1 height)
// are written on cfg_valid, which is always ready; write only while idle.
`default_nettype none
module dirty_rectangle_merge_table
	import drm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         kind,
	input  wire logic signed [15:0] rect_x,
	input  wire logic signed [15:0] rect_y,
	input  wire logic [14:0]        rect_w,
	input  wire logic [14:0]        rect_h,
	output logic                    done,
	output logic [2:0]              status,
	output logic signed [15:0]      out_x,
	output logic signed [15:0]      out_y,
	output logic [14:0]             out_w,
	output logic [14:0]             out_h,
	output logic                    last,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [14:0]        cfg_data
);

	cmd_t        cmd;
	flg_t        flg;
	logic [14:0] cw_q, ch_q;

	assign cfg_ready = 1'b1;

	// canvas size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= 15'd1024;
			ch_q <= 15'd768;
		end else if (cfg_valid) begin
			if (cfg_index) ch_q <= cfg_data;
			else cw_q <= cfg_data;
		end
	end

	drm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.flg    (flg),
		.cmd    (cmd),
		.busy   (busy)
	);

	drm_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.kind   (kind),
		.rect_x (rect_x),
		.rect_y (rect_y),
		.rect_w (rect_w),
		.rect_h (rect_h),
		.cw     (cw_q),
		.ch     (ch_q),
		.flg    (flg),
		.done   (done),
		.status (status),
		.out_x  (out_x),
		.out_y  (out_y),
		.out_w  (out_w),
		.out_h  (out_h),
		.last   (last)
	);

endmodule
`default_nettype wire

/* tb/sv/tb_dirty_rectangle_merge_table.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_dirty_rectangle_merge_table
	import drm_pkg::*;
();

	// kind 3 is decoded as a plain rectangle invalidate
	localparam logic [1:0] KIND_ALIAS = 2'd3;
	localparam int TBL_DEPTH = 16;
	localparam longint DIM_LIMIT = 32767;
	localparam int CFG_WIDTH = 0;
	localparam int CFG_HEIGHT = 1;
	localparam int N_RANDOM = 285;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] kind;
	logic signed [15:0] rect_x;
	logic signed [15:0] rect_y;
	logic [14:0] rect_w;
	logic [14:0] rect_h;
	logic done;
	logic [2:0] status;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic [14:0] out_w;
	logic [14:0] out_h;
	logic last;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [14:0] cfg_data;

	dirty_rectangle_merge_table DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h),
		.done(done), .status(status), .out_x(out_x), .out_y(out_y),
		.out_w(out_w), .out_h(out_h), .last(last), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// rectangle held at full precision so that walk covers never wrap
	typedef struct {
		longint x;
		longint y;
		longint w;
		longint h;
	} rect_t;

	typedef struct {
		st_t                st;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
		logic               lst;
	} region_result_t;

	// one row of the directed table; chk_st marks a status read straight off the rules
	typedef struct {
		logic [1:0]         k;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
		bit                 chk_st;
		st_t                st;
	} dir_row_t;

	// shadow copy of the block's state
	rect_t          shadow_tbl [TBL_DEPTH];
	int             shadow_cnt;
	longint         canvas_w;
	longint         canvas_h;
	region_result_t pending_results[$];
	int             mismatches;
	dir_row_t       dir_rows[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop, well beyond the slowest legal run
	initial begin
		#10ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void enqueue_result(region_result_t r);
		pending_results = {pending_results, r};
	endfunction

	function automatic bit rect_empty(rect_t a);
		return a.w <= 0 || a.h <= 0;
	endfunction

	function automatic longint rect_area(rect_t a);
		return a.w * a.h;
	endfunction

	function automatic bit rect_holds(rect_t a, rect_t b);
		return a.x <= b.x && a.y <= b.y && a.x + a.w >= b.x + b.w &&
			a.y + a.h >= b.y + b.h;
	endfunction

	function automatic rect_t rect_cover(rect_t a, rect_t b);
		rect_t r;
		longint x2;
		longint y2;
		if (rect_empty(a))
			return b;
		if (rect_empty(b))
			return a;
		r.x = (a.x < b.x) ? a.x : b.x;
		r.y = (a.y < b.y) ? a.y : b.y;
		x2 = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
		y2 = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
		r.w = x2 - r.x;
		r.h = y2 - r.y;
		return r;
	endfunction

	function automatic rect_t rect_clamp(rect_t a);
		if (a.w > DIM_LIMIT) a.w = DIM_LIMIT;
		if (a.h > DIM_LIMIT) a.h = DIM_LIMIT;
		if (a.w < 0) a.w = 0;
		if (a.h < 0) a.h = 0;
		return a;
	endfunction

	// walk the shadow table with a new dirty rectangle
	function automatic st_t table_insert(rect_t nr);
		rect_t run_cover;
		rect_t e;
		rect_t m;
		longint run_area;
		run_cover = nr;
		run_area = 0;
		for (int i = 0; i < shadow_cnt; i++) begin
			e = shadow_tbl[i];
			if (rect_holds(e, nr))
				return ST_IGNORED;
			if (rect_holds(nr, e)) begin
				shadow_tbl[i] = rect_clamp(nr);
				return ST_SUPER;
			end
			m = rect_cover(e, nr);
			if (rect_area(m) <= rect_area(e) + rect_area(nr)) begin
				shadow_tbl[i] = rect_clamp(m);
				return ST_MERGED;
			end
			run_cover = rect_cover(run_cover, e);
			run_area += rect_area(e);
			if (rect_area(run_cover) <= run_area) begin
				shadow_tbl[0] = rect_clamp(run_cover);
				return ST_CONGLOM;
			end
		end
		if (shadow_cnt < TBL_DEPTH) begin
			shadow_tbl[shadow_cnt] = rect_clamp(nr);
			shadow_cnt++;
			return ST_APPENDED;
		end
		shadow_tbl[0] = rect_clamp(rect_cover(shadow_tbl[0], nr));
		return ST_OVERFLOW;
	endfunction

	// expected results of one accepted request, queued on pending_results
	function automatic void predict_regions(logic [1:0] k, logic signed [15:0] x,
			logic signed [15:0] y, logic [14:0] w, logic [14:0] h, bit chk_st, st_t st);
		region_result_t res;
		rect_t nr;
		rect_t top;
		rect_t m;
		bit absorbed;
		int emitted;
		res = '{ST_IGNORED, '0, '0, '0, '0, 1'b0};
		if (k == KIND_DRAIN) begin
			emitted = 0;
			while (shadow_cnt > 0 && emitted < TBL_DEPTH) begin
				top = shadow_tbl[shadow_cnt - 1];
				shadow_cnt--;
				absorbed = 1'b0;
				for (int j = 0; j < shadow_cnt && !absorbed; j++) begin
					if (rect_holds(shadow_tbl[j], top)) begin
						absorbed = 1'b1;
					end else begin
						m = rect_cover(shadow_tbl[j], top);
						if (rect_area(m) <= rect_area(top) + rect_area(shadow_tbl[j])) begin
							shadow_tbl[j] = rect_clamp(m);
							absorbed = 1'b1;
						end
					end
				end
				if (!absorbed) begin
					res.st = ST_EMIT;
					res.x = 16'(top.x);
					res.y = 16'(top.y);
					res.w = 15'(top.w);
					res.h = 15'(top.h);
					res.lst = 1'b0;
					enqueue_result(res);
					emitted++;
				end
			end
			if (emitted == 0) begin
				res = '{ST_EMPTY, '0, '0, '0, '0, 1'b0};
				enqueue_result(res);
			end
			if (chk_st) pending_results[$].st = st;
			pending_results[$].lst = 1'b1;
		end else begin
			if (k == KIND_CANVAS)
				nr = '{0, 0, canvas_w, canvas_h};
			else
				nr = '{longint'(x), longint'(y), longint'(w), longint'(h)};
			res.st = table_insert(nr);
			if (chk_st) res.st = st;
			res.lst = 1'b1;
			enqueue_result(res);
		end
	endfunction

	// done cannot be held off: every strobe is checked against the oldest expectation
	always @(posedge clk) begin
		region_result_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result status=%0d", $realtime, status);
			end else begin
				exp_res = pending_results.pop_front();
				if (status !== exp_res.st || out_x !== exp_res.x || out_y !== exp_res.y ||
						out_w !== exp_res.w || out_h !== exp_res.h || last !== exp_res.lst) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected st=%0d xywh=%0d,%0d,%0d,%0d last=%0b got st=%0d xywh=%0d,%0d,%0d,%0d last=%0b",
							$realtime, exp_res.st, exp_res.x, exp_res.y, exp_res.w, exp_res.h,
							exp_res.lst, status, out_x, out_y, out_w, out_h, last);
				end
			end
		end
	end

	// start is left high; the next request or idle_cycles decides its level
	task automatic issue_request(logic [1:0] k, logic signed [15:0] x, logic signed [15:0] y,
			logic [14:0] w, logic [14:0] h, bit chk_st, st_t st);
		start <= 1'b1;
		kind <= k;
		rect_x <= x;
		rect_y <= y;
		rect_w <= w;
		rect_h <= h;
		do @(posedge clk); while (busy);
		predict_regions(k, x, y, w, h, chk_st, st);
	endtask

	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// only called with the table walk finished and nothing outstanding
	task automatic write_canvas(int idx, logic [14:0] val);
		start <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx[0];
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_WIDTH) canvas_w = val;
		else canvas_h = val;
		cfg_valid <= 1'b0;
	endtask

	function automatic void add_row(logic [1:0] k, int x, int y, int w, int h,
			bit chk_st, st_t st);
		dir_row_t r;
		r = '{k, 16'(x), 16'(y), 15'(w), 15'(h), chk_st, st};
		dir_rows = {dir_rows, r};
	endfunction

	initial begin
		int idle_pct [4];
		logic [1:0] k;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0] w;
		logic [14:0] h;
		int sel;
		idle_pct = '{0, 83, 0, 22};
		mismatches = 0;
		shadow_cnt = 0;
		canvas_w = 1024;
		canvas_h = 768;
		foreach (shadow_tbl[i]) shadow_tbl[i] = '{0, 0, 0, 0};
		arst_n <= 1'b0;
		start <= 1'b0;
		kind <= KIND_RECT;
		rect_x <= '0;
		rect_y <= '0;
		rect_w <= '0;
		rect_h <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= 1'b0;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty drain, containment both ways, extremes, empties, overflow
		add_row(KIND_DRAIN, 0, 0, 0, 0, 1, ST_EMPTY);
		add_row(KIND_RECT, 0, 0, 10, 10, 1, ST_APPENDED);
		add_row(KIND_RECT, 2, 2, 3, 3, 1, ST_IGNORED);
		add_row(KIND_RECT, -5, -5, 20, 20, 1, ST_SUPER);
		add_row(KIND_RECT, 16, -5, 20, 20, 0, ST_IGNORED);
		add_row(KIND_RECT, -32768, -32768, 32767, 32767, 0, ST_IGNORED);
		add_row(KIND_ALIAS, 32767, 32767, 32767, 32767, 0, ST_IGNORED);
		add_row(KIND_RECT, 100, 100, 0, 5, 0, ST_IGNORED);
		add_row(KIND_CANVAS, 0, 0, 0, 0, 0, ST_IGNORED);
		add_row(KIND_DRAIN, 0, 0, 0, 0, 0, ST_IGNORED);
		add_row(KIND_DRAIN, 0, 0, 0, 0, 1, ST_EMPTY);
		// sixteen spaced pixels fill the table, the seventeenth overflows
		for (int i = 0; i < TBL_DEPTH; i++)
			add_row(KIND_RECT, i * 100, 0, 1, 1, 1, ST_APPENDED);
		add_row(KIND_RECT, 5000, 5000, 1, 1, 1, ST_OVERFLOW);
		add_row(KIND_DRAIN, 0, 0, 0, 0, 0, ST_IGNORED);
		foreach (dir_rows[i])
			issue_request(dir_rows[i].k, dir_rows[i].x, dir_rows[i].y, dir_rows[i].w,
				dir_rows[i].h, dir_rows[i].chk_st, dir_rows[i].st);

		// random phases, each under its own canvas setting and sender idling
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_canvas(CFG_WIDTH, 15'd0);
					write_canvas(CFG_HEIGHT, 15'd0);
				end
				1: begin
					write_canvas(CFG_WIDTH, 15'h7fff);
					write_canvas(CFG_HEIGHT, 15'h7fff);
				end
				2: begin
					write_canvas(CFG_WIDTH, 15'($urandom));
					write_canvas(CFG_HEIGHT, 15'($urandom));
				end
				default: begin
					write_canvas(CFG_WIDTH, 15'd64);
					write_canvas(CFG_HEIGHT, 15'd48);
				end
			endcase
			for (int n = 0; n < N_RANDOM / 4; n++) begin
				sel = $urandom_range(99);
				if (sel < 10) k = KIND_DRAIN;
				else if (sel < 16) k = KIND_CANVAS;
				else if (sel < 21) k = KIND_ALIAS;
				else k = KIND_RECT;
				// mostly small clustered rectangles so merges and covers are common
				sel = $urandom_range(99);
				if (sel < 75) begin
					x = 16'($urandom_range(80)) - 16'sd8;
					y = 16'($urandom_range(80)) - 16'sd8;
					w = 15'($urandom_range(40));
					h = 15'($urandom_range(40));
				end else if (sel < 90) begin
					x = 16'($urandom);
					y = 16'($urandom);
					w = 15'($urandom);
					h = 15'($urandom);
				end else begin
					x = $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(3)) :
						16'sh8000 + 16'($urandom_range(3));
					y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
					w = 15'h7fff - 15'($urandom_range(3));
					h = $urandom_range(1) ? 15'h7fff : 15'd0;
				end
				issue_request(k, x, y, w, h, 0, ST_IGNORED);
				if ($urandom_range(99) < idle_pct[ph])
					idle_cycles($urandom_range(1, 6));
			end
		end

		// final drain so remaining entries are emitted and checked
		issue_request(KIND_DRAIN, '0, '0, '0, '0, 0, ST_IGNORED);
		start <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
